@@ rtl/core/mmcfp_pkg.sv @@
// shared types and constants of the motor command frame packer
`default_nettype none

package mmcfp_pkg;

    // lanes of the five command values
    localparam int LANES       = 5;
    localparam int LANE_POS    = 0;
    localparam int LANE_SPD    = 1;
    localparam int LANE_STIFF  = 2;
    localparam int LANE_DAMP   = 3;
    localparam int LANE_TORQUE = 4;

    // code widths and datapath widths
    localparam int POS_BITS  = 16;
    localparam int GAIN_BITS = 12;
    localparam int VAL_W     = 32;
    localparam int LIM_W     = 31;
    localparam int SPAN_W    = 32;
    localparam int NUM_W     = SPAN_W + POS_BITS;
    localparam int QUO_W     = POS_BITS;
    localparam int STEPS     = POS_BITS;

    // register map
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_POS_MIN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POS_MAX    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPD_MIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPD_MAX    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TORQUE_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TORQUE_MAX = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STIFF_MAX  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_MAX   = 3'd7;

    localparam logic signed [VAL_W-1:0] RST_POS_MIN    = -32'sd819200;
    localparam logic signed [VAL_W-1:0] RST_POS_MAX    = 32'sd819200;
    localparam logic signed [VAL_W-1:0] RST_SPD_MIN    = -32'sd1966080;
    localparam logic signed [VAL_W-1:0] RST_SPD_MAX    = 32'sd1966080;
    localparam logic signed [VAL_W-1:0] RST_TORQUE_MIN = -32'sd655360;
    localparam logic signed [VAL_W-1:0] RST_TORQUE_MAX = 32'sd655360;
    localparam logic [LIM_W-1:0]        RST_STIFF_MAX  = 31'd32768000;
    localparam logic [LIM_W-1:0]        RST_DAMP_MAX   = 31'd327680;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [LIM_W-1:0]        lim_t;

    typedef struct packed {
        val_t pos_min;
        val_t pos_max;
        val_t spd_min;
        val_t spd_max;
        val_t torque_min;
        val_t torque_max;
        lim_t stiff_max;
        lim_t damp_max;
    } cfg_t;

    // one command as it enters the datapath
    typedef struct packed {
        logic                             hybrid;
        logic [LANES-1:0][VAL_W-1:0]      x;
    } cmd_t;

    // scaled numerators and spans, ready for the divider
    typedef struct packed {
        logic                             hybrid;
        logic [LANES-1:0]                 zero;
        logic [LANES-1:0][SPAN_W-1:0]     span;
        logic [LANES-1:0][NUM_W-1:0]      num;
    } div_in_t;

    // codes as they leave the divider
    typedef struct packed {
        logic                             hybrid;
        logic [LANES-1:0]                 zero;
        logic [LANES-1:0][QUO_W-1:0]      quo;
    } div_out_t;

endpackage

`default_nettype wire

@@ rtl/core/mmcfp_if.sv @@
// command and frame channel interfaces
`default_nettype none

interface mmcfp_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_pos;
    logic signed [31:0] target_spd;
    logic signed [31:0] stiff_gain;
    logic signed [31:0] damp_gain;
    logic signed [31:0] ff_torque;
    logic               mode_is_hybrid;

    modport source (
        output valid, target_pos, target_spd, stiff_gain, damp_gain, ff_torque,
               mode_is_hybrid,
        input  ready
    );
    modport sink (
        input  valid, target_pos, target_spd, stiff_gain, damp_gain, ff_torque,
               mode_is_hybrid,
        output ready
    );
endinterface

interface mmcfp_frame_if;
    logic       valid;
    logic       ready;
    logic       need_mode_switch;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;

    modport source (
        output valid, need_mode_switch, byte0, byte1, byte2, byte3, byte4, byte5,
               byte6, byte7,
        input  ready
    );
    modport sink (
        input  valid, need_mode_switch, byte0, byte1, byte2, byte3, byte4, byte5,
               byte6, byte7,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/mmcfp_regs.sv @@
// apb register file holding the range limits
`default_nettype none

module mmcfp_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mmcfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mmcfp_pkg::DATA_W-1:0] pwdata,
    output logic      [mmcfp_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    output mmcfp_pkg::cfg_t                   cfg
);
    import mmcfp_pkg::*;

    val_t pos_min_reg;
    val_t pos_max_reg;
    val_t spd_min_reg;
    val_t spd_max_reg;
    val_t torque_min_reg;
    val_t torque_max_reg;
    lim_t stiff_max_reg;
    lim_t damp_max_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_min_reg    <= RST_POS_MIN;
            pos_max_reg    <= RST_POS_MAX;
            spd_min_reg    <= RST_SPD_MIN;
            spd_max_reg    <= RST_SPD_MAX;
            torque_min_reg <= RST_TORQUE_MIN;
            torque_max_reg <= RST_TORQUE_MAX;
            stiff_max_reg  <= RST_STIFF_MAX;
            damp_max_reg   <= RST_DAMP_MAX;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_POS_MIN:    pos_min_reg    <= pwdata;
                REG_POS_MAX:    pos_max_reg    <= pwdata;
                REG_SPD_MIN:    spd_min_reg    <= pwdata;
                REG_SPD_MAX:    spd_max_reg    <= pwdata;
                REG_TORQUE_MIN: torque_min_reg <= pwdata;
                REG_TORQUE_MAX: torque_max_reg <= pwdata;
                REG_STIFF_MAX:  stiff_max_reg  <= pwdata[LIM_W-1:0];
                REG_DAMP_MAX:   damp_max_reg   <= pwdata[LIM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POS_MIN:    prdata = pos_min_reg;
            REG_POS_MAX:    prdata = pos_max_reg;
            REG_SPD_MIN:    prdata = spd_min_reg;
            REG_SPD_MAX:    prdata = spd_max_reg;
            REG_TORQUE_MIN: prdata = torque_min_reg;
            REG_TORQUE_MAX: prdata = torque_max_reg;
            REG_STIFF_MAX:  prdata = {1'b0, stiff_max_reg};
            REG_DAMP_MAX:   prdata = {1'b0, damp_max_reg};
        endcase
    end

    assign cfg = '{pos_min:    pos_min_reg,
                   pos_max:    pos_max_reg,
                   spd_min:    spd_min_reg,
                   spd_max:    spd_max_reg,
                   torque_min: torque_min_reg,
                   torque_max: torque_max_reg,
                   stiff_max:  stiff_max_reg,
                   damp_max:   damp_max_reg};

endmodule

`default_nettype wire

@@ rtl/core/mmcfp_prep.sv @@
// offset, clamp and scale stages ahead of the divider
`default_nettype none

module mmcfp_prep (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mmcfp_pkg::cfg_t    cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mmcfp_pkg::cmd_t    in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mmcfp_pkg::div_in_t      out_data
);
    import mmcfp_pkg::*;

    // stage 1: offset from range low and span
    logic                          s1_vld_reg;
    logic                          s1_hyb_reg;
    logic [LANES-1:0][VAL_W:0]     s1_d_reg;
    logic [LANES-1:0][VAL_W:0]     s1_span_reg;
    logic [LANES-1:0][VAL_W:0]     s1_d_next;
    logic [LANES-1:0][VAL_W:0]     s1_span_next;
    logic [LANES-1:0][VAL_W:0]     lo_ext;
    logic [LANES-1:0][VAL_W:0]     hi_ext;

    // stage 2: offset clamped into [0, span]
    logic                          s2_vld_reg;
    logic                          s2_hyb_reg;
    logic [LANES-1:0]              s2_zero_reg;
    logic [LANES-1:0][SPAN_W-1:0]  s2_dc_reg;
    logic [LANES-1:0][SPAN_W-1:0]  s2_span_reg;
    logic [LANES-1:0]              s2_zero_next;
    logic [LANES-1:0][SPAN_W-1:0]  s2_dc_next;

    // stage 3: numerator times 2^n - 1
    logic                          s3_vld_reg;
    div_in_t                       s3_reg;
    logic [LANES-1:0][NUM_W-1:0]   s3_num_next;

    logic rdy1;
    logic rdy2;
    logic rdy3;

    assign rdy3     = !s3_vld_reg || out_ready;
    assign rdy2     = !s2_vld_reg || rdy3;
    assign rdy1     = !s1_vld_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        lo_ext[LANE_POS]    = {cfg.pos_min[VAL_W-1], cfg.pos_min};
        hi_ext[LANE_POS]    = {cfg.pos_max[VAL_W-1], cfg.pos_max};
        lo_ext[LANE_SPD]    = {cfg.spd_min[VAL_W-1], cfg.spd_min};
        hi_ext[LANE_SPD]    = {cfg.spd_max[VAL_W-1], cfg.spd_max};
        lo_ext[LANE_STIFF]  = '0;
        hi_ext[LANE_STIFF]  = {2'b00, cfg.stiff_max};
        lo_ext[LANE_DAMP]   = '0;
        hi_ext[LANE_DAMP]   = {2'b00, cfg.damp_max};
        lo_ext[LANE_TORQUE] = {cfg.torque_min[VAL_W-1], cfg.torque_min};
        hi_ext[LANE_TORQUE] = {cfg.torque_max[VAL_W-1], cfg.torque_max};
        for (int l = 0; l < LANES; l++)
        begin
            s1_d_next[l]    = {in_data.x[l][VAL_W-1], in_data.x[l]} - lo_ext[l];
            s1_span_next[l] = hi_ext[l] - lo_ext[l];
        end
    end

    // clamping the offset matches clamping the value whenever span is positive
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            s2_zero_next[l] = s1_span_reg[l][VAL_W] || (s1_span_reg[l] == '0);
            if (s1_d_reg[l][VAL_W])
                s2_dc_next[l] = '0;
            else if ($signed(s1_d_reg[l]) > $signed(s1_span_reg[l]))
                s2_dc_next[l] = s1_span_reg[l][SPAN_W-1:0];
            else
                s2_dc_next[l] = s1_d_reg[l][SPAN_W-1:0];
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (l == LANE_POS)
                s3_num_next[l] = (NUM_W'(s2_dc_reg[l]) << POS_BITS) - NUM_W'(s2_dc_reg[l]);
            else
                s3_num_next[l] = (NUM_W'(s2_dc_reg[l]) << GAIN_BITS) - NUM_W'(s2_dc_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_vld_reg <= in_valid;
            if (rdy2)
                s2_vld_reg <= s1_vld_reg;
            if (rdy3)
                s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_hyb_reg  <= in_data.hybrid;
            s1_d_reg    <= s1_d_next;
            s1_span_reg <= s1_span_next;
        end
        if (rdy2 && s1_vld_reg)
        begin
            s2_hyb_reg  <= s1_hyb_reg;
            s2_zero_reg <= s2_zero_next;
            s2_dc_reg   <= s2_dc_next;
            for (int l = 0; l < LANES; l++)
                s2_span_reg[l] <= s1_span_reg[l][SPAN_W-1:0];
        end
        if (rdy3 && s2_vld_reg)
        begin
            s3_reg.hybrid <= s2_hyb_reg;
            s3_reg.zero   <= s2_zero_reg;
            s3_reg.span   <= s2_span_reg;
            s3_reg.num    <= s3_num_next;
        end
    end

    assign out_valid = s3_vld_reg;
    assign out_data  = s3_reg;

endmodule

`default_nettype wire

@@ rtl/core/mmcfp_div.sv @@
// restoring divider, one quotient bit per stage for all five lanes
`default_nettype none

module mmcfp_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mmcfp_pkg::div_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mmcfp_pkg::div_out_t     out_data
);
    import mmcfp_pkg::*;

    typedef struct packed {
        div_in_t                      base;
        logic [LANES-1:0][QUO_W-1:0]  quo;
    } stage_t;

    stage_t           stg_reg [STEPS];
    logic [STEPS-1:0] vld_reg;
    logic [STEPS:0]   rdy;

    assign rdy[STEPS] = out_ready;
    assign in_ready   = rdy[0];

    for (genvar g = 0; g < STEPS; g++)
    begin : g_step
        localparam int K = STEPS - 1 - g;

        stage_t                      src;
        logic                        src_vld;
        stage_t                      stg_next;
        logic [LANES-1:0][NUM_W-1:0] cand;

        if (g == 0)
        begin : g_first
            assign src     = '{base: in_data, quo: '0};
            assign src_vld = in_valid;
        end
        else
        begin : g_rest
            assign src     = stg_reg[g-1];
            assign src_vld = vld_reg[g-1];
        end

        assign rdy[g] = !vld_reg[g] || rdy[g+1];

        // base.num carries the partial remainder
        always_comb
        begin
            stg_next = src;
            for (int l = 0; l < LANES; l++)
            begin
                cand[l] = NUM_W'(src.base.span[l]) << K;
                if (src.base.num[l] >= cand[l])
                begin
                    stg_next.base.num[l] = src.base.num[l] - cand[l];
                    stg_next.quo[l][K]   = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (rdy[g])
                vld_reg[g] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[g] && src_vld)
                stg_reg[g] <= stg_next;
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_data  = '{hybrid: stg_reg[STEPS-1].base.hybrid,
                         zero:   stg_reg[STEPS-1].base.zero,
                         quo:    stg_reg[STEPS-1].quo};

`ifndef SYNTHESIS
    // a stalled last stage keeps its item
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STEPS-1] && !out_ready |=> vld_reg[STEPS-1] && $stable(stg_reg[STEPS-1]))
        else $error("divider last stage changed while stalled");

    // gain lanes never carry past twelve bits
    a_gain_width: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STEPS-1] |->
            (stg_reg[STEPS-1].base.zero[LANE_SPD]
                || stg_reg[STEPS-1].quo[LANE_SPD][QUO_W-1:GAIN_BITS] == '0)
            && (stg_reg[STEPS-1].base.zero[LANE_STIFF]
                || stg_reg[STEPS-1].quo[LANE_STIFF][QUO_W-1:GAIN_BITS] == '0)
            && (stg_reg[STEPS-1].base.zero[LANE_DAMP]
                || stg_reg[STEPS-1].quo[LANE_DAMP][QUO_W-1:GAIN_BITS] == '0)
            && (stg_reg[STEPS-1].base.zero[LANE_TORQUE]
                || stg_reg[STEPS-1].quo[LANE_TORQUE][QUO_W-1:GAIN_BITS] == '0))
        else $error("gain code wider than twelve bits");

    // final position remainder stays below the divisor
    a_pos_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STEPS-1] && !stg_reg[STEPS-1].base.zero[LANE_POS] |->
            stg_reg[STEPS-1].base.num[LANE_POS] < NUM_W'(stg_reg[STEPS-1].base.span[LANE_POS]))
        else $error("position remainder not below span");
`endif

endmodule

`default_nettype wire

@@ rtl/core/mit_motor_command_frame_pack.sv @@
// hybrid-mode motor command to 8-byte frame payload packer
//
// usage:
//   cmd   : sink of command beats (target_pos, target_spd, stiff_gain,
//           damp_gain, ff_torque as signed q16.16, and mode_is_hybrid)
//   frame : source of frame beats (need_mode_switch and byte0..byte7)
//   apb   : range limits, register i at byte address 4*i, pready always high
//   each value is clamped to its range and mapped to a 16 bit (position) or
//   12 bit (speed, gains, torque) code, floor((x-min)*(2^n-1)/(max-min));
//   an empty or inverted range gives code zero
//   a command with mode_is_hybrid low yields need_mode_switch high and a
//   zero payload
// pipeline:
//   command beat to frame beat passes 3 offset/clamp/scale stages,
//   16 restoring divider stages (one quotient bit each), 1 output register
//   one beat per cycle sustained while the receiver keeps ready high
// stall:
//   each stage has its own valid bit and holds while the next one is full and
//   stalled, so a stalled receiver backs up the pipe stage by stage and bubbles close
// reset:
//   rst_n clears every valid bit and loads the default range limits
`default_nettype none

module mit_motor_command_frame_pack (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    mmcfp_cmd_if.sink                         cmd,
    mmcfp_frame_if.source                     frame,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mmcfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mmcfp_pkg::DATA_W-1:0] pwdata,
    output logic      [mmcfp_pkg::DATA_W-1:0] prdata,
    output logic                              pready
);
    import mmcfp_pkg::*;

    cfg_t     cfg;
    cmd_t     cmd_data;

    // prep to divider
    logic     prep_valid;
    logic     prep_ready;
    div_in_t  prep_data;

    // divider to output register
    logic     div_valid;
    logic     div_ready;
    div_out_t div_data;

    // output register
    logic       out_vld_reg;
    logic       nms_reg;
    logic [7:0] byte_reg [8];
    logic       nms_next;
    logic [7:0] byte_next [8];

    logic [POS_BITS-1:0]  p_code;
    logic [GAIN_BITS-1:0] v_code;
    logic [GAIN_BITS-1:0] kp_code;
    logic [GAIN_BITS-1:0] kd_code;
    logic [GAIN_BITS-1:0] t_code;

    mmcfp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        cmd_data.hybrid         = cmd.mode_is_hybrid;
        cmd_data.x[LANE_POS]    = cmd.target_pos;
        cmd_data.x[LANE_SPD]    = cmd.target_spd;
        cmd_data.x[LANE_STIFF]  = cmd.stiff_gain;
        cmd_data.x[LANE_DAMP]   = cmd.damp_gain;
        cmd_data.x[LANE_TORQUE] = cmd.ff_torque;
    end

    mmcfp_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .in_data   (cmd_data),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    mmcfp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // empty or inverted ranges force the code to zero
    always_comb
    begin
        p_code  = div_data.zero[LANE_POS]    ? '0 : div_data.quo[LANE_POS];
        v_code  = div_data.zero[LANE_SPD]    ? '0 : div_data.quo[LANE_SPD][GAIN_BITS-1:0];
        kp_code = div_data.zero[LANE_STIFF]  ? '0 : div_data.quo[LANE_STIFF][GAIN_BITS-1:0];
        kd_code = div_data.zero[LANE_DAMP]   ? '0 : div_data.quo[LANE_DAMP][GAIN_BITS-1:0];
        t_code  = div_data.zero[LANE_TORQUE] ? '0 : div_data.quo[LANE_TORQUE][GAIN_BITS-1:0];

        nms_next     = !div_data.hybrid;
        byte_next[0] = p_code[15:8];
        byte_next[1] = p_code[7:0];
        byte_next[2] = v_code[11:4];
        byte_next[3] = {v_code[3:0], kp_code[11:8]};
        byte_next[4] = kp_code[7:0];
        byte_next[5] = kd_code[11:4];
        byte_next[6] = {kd_code[3:0], t_code[11:8]};
        byte_next[7] = t_code[7:0];

        // not in hybrid mode: mode-switch request with a blank payload
        if (!div_data.hybrid)
        begin
            for (int b = 0; b < 8; b++)
                byte_next[b] = '0;
        end
    end

    // output register parts the divider from the receiver
    assign div_ready = !out_vld_reg || frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (div_ready)
            out_vld_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (div_ready && div_valid)
        begin
            nms_reg <= nms_next;
            for (int b = 0; b < 8; b++)
                byte_reg[b] <= byte_next[b];
        end
    end

    assign frame.valid            = out_vld_reg;
    assign frame.need_mode_switch = nms_reg;
    assign frame.byte0            = byte_reg[0];
    assign frame.byte1            = byte_reg[1];
    assign frame.byte2            = byte_reg[2];
    assign frame.byte3            = byte_reg[3];
    assign frame.byte4            = byte_reg[4];
    assign frame.byte5            = byte_reg[5];
    assign frame.byte6            = byte_reg[6];
    assign frame.byte7            = byte_reg[7];

`ifndef SYNTHESIS
    // a mode-switch request always goes out with a blank payload
    a_nms_blank: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.need_mode_switch |->
            frame.byte0 == 8'h00 && frame.byte1 == 8'h00 && frame.byte2 == 8'h00
            && frame.byte3 == 8'h00 && frame.byte4 == 8'h00 && frame.byte5 == 8'h00
            && frame.byte6 == 8'h00 && frame.byte7 == 8'h00)
        else $error("mode-switch beat with nonzero payload");

    // an empty output register opens the whole pipe to the command side
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !frame.valid |-> cmd.ready)
        else $error("command side blocked with empty output register");

    // a taken beat with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready && !div_valid |=> !frame.valid)
        else $error("output beat repeated after drain");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench for the hybrid-mode motor command frame packer
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mmcfp_pkg::*;

    // extremes of a signed q16.16 value, in 32 and 64 bit form
    localparam val_t   Q_MIN = 32'sh8000_0000;
    localparam val_t   Q_MAX = 32'sh7fff_ffff;
    localparam longint Q_MIN_L = -64'sd2147483648;
    localparam longint Q_MAX_L = 64'sd2147483647;

    // full-scale codes of the two code widths
    localparam longint POS_TOP  = (64'sd1 << POS_BITS) - 1;
    localparam longint GAIN_TOP = (64'sd1 << GAIN_BITS) - 1;

    // one frame beat as the receiver sees it; payload[0] is byte0
    typedef struct packed {
        logic            need_mode_switch;
        logic [0:7][7:0] payload;
    } frame_t;

    logic clk;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mmcfp_cmd_if   cmd_bus();
    mmcfp_frame_if frame_bus();

    mit_motor_command_frame_pack DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .frame   (frame_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the range registers, kept in step with every apb write
    val_t pos_lo, pos_hi, spd_lo, spd_hi, trq_lo, trq_hi;
    lim_t stiff_hi, damp_hi;

    // frames still owed by the block, oldest first
    frame_t frames_pending[$];
    int     mismatches;

    // idling switches for the command sender and the frame receiver
    bit idle_send;
    bit idle_recv;
    int recv_stall_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: far beyond the slowest legal run (about 1150 beats through the
    // pipe, idle gaps on both sides, a handful of drains and apb writes)
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // saturate a wide value back into the q16.16 range
    function automatic val_t clip_q(input longint v);
        if (v > Q_MAX_L)
            return Q_MAX;
        if (v < Q_MIN_L)
            return Q_MIN;
        return val_t'(v);
    endfunction

    // clamp into [lo, hi] then floor((v - lo) * top / (hi - lo)); empty range gives 0
    function automatic logic [15:0] scale_code(input val_t x, input longint lo,
                                               input longint hi, input longint top);
        longint v;
        longint span;
        v    = x;
        span = hi - lo;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        if (span <= 0)
            return '0;
        return 16'(((v - lo) * top) / span);
    endfunction

    // expected frame for one command under the current register mirror
    function automatic frame_t pack_frame(input val_t p, input val_t s, input val_t k,
                                          input val_t d, input val_t t, input logic hybrid);
        frame_t      f;
        logic [15:0] pc;
        logic [15:0] sc;
        logic [15:0] kc;
        logic [15:0] dc;
        logic [15:0] tc;
        f = '0;
        if (!hybrid)
        begin
            // motor not in hybrid mode yet: ask for the switch, empty payload
            f.need_mode_switch = 1'b1;
            return f;
        end
        pc = scale_code(p, pos_lo, pos_hi, POS_TOP);
        sc = scale_code(s, spd_lo, spd_hi, GAIN_TOP);
        kc = scale_code(k, 0, stiff_hi, GAIN_TOP);
        dc = scale_code(d, 0, damp_hi, GAIN_TOP);
        tc = scale_code(t, trq_lo, trq_hi, GAIN_TOP);
        f.payload[0] = pc[15:8];
        f.payload[1] = pc[7:0];
        f.payload[2] = sc[11:4];
        f.payload[3] = {sc[3:0], kc[11:8]};
        f.payload[4] = kc[7:0];
        f.payload[5] = dc[11:4];
        f.payload[6] = {dc[3:0], tc[11:8]};
        f.payload[7] = tc[7:0];
        return f;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] seen_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want_v, seen_v);
    endtask

    // receiver: checks every frame beat and throttles ready in short bursts
    always @(posedge clk)
    begin
        frame_t seen;
        frame_t want;
        if (rst_n && frame_bus.valid && frame_bus.ready)
        begin
            seen.need_mode_switch = frame_bus.need_mode_switch;
            seen.payload = {frame_bus.byte0, frame_bus.byte1, frame_bus.byte2,
                            frame_bus.byte3, frame_bus.byte4, frame_bus.byte5,
                            frame_bus.byte6, frame_bus.byte7};
            if (frames_pending.size() == 0)
            begin
                log_mismatch("frame beat with no command pending", 32'd0,
                             32'(seen.need_mode_switch));
            end
            else
            begin
                want = frames_pending.pop_front();
                if (seen.need_mode_switch !== want.need_mode_switch)
                    log_mismatch("need_mode_switch", 32'(want.need_mode_switch),
                                 32'(seen.need_mode_switch));
                for (int i = 0; i < 8; i++)
                    if (seen.payload[i] !== want.payload[i])
                        log_mismatch($sformatf("byte%0d", i), 32'(want.payload[i]),
                                     32'(seen.payload[i]));
            end
        end
        // random stall bursts, counted down in recv_stall_left
        if (recv_stall_left != 0)
        begin
            frame_bus.ready <= 1'b0;
            recv_stall_left--;
        end
        else if (idle_recv && $urandom_range(0, 4) == 0)
        begin
            frame_bus.ready <= 1'b0;
            recv_stall_left = $urandom_range(0, 2);
        end
        else
        begin
            frame_bus.ready <= 1'b1;
        end
    end

    // one apb write (setup then access), then idle; mirror follows
    task automatic write_limit(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POS_MIN:    pos_lo   = value;
            REG_POS_MAX:    pos_hi   = value;
            REG_SPD_MIN:    spd_lo   = value;
            REG_SPD_MAX:    spd_hi   = value;
            REG_TORQUE_MIN: trq_lo   = value;
            REG_TORQUE_MAX: trq_hi   = value;
            REG_STIFF_MAX:  stiff_hi = value[LIM_W-1:0];
            REG_DAMP_MAX:   damp_hi  = value[LIM_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all_limits(input val_t plo, input val_t phi, input val_t slo,
                                    input val_t shi, input val_t tlo, input val_t thi,
                                    input logic [DATA_W-1:0] kmax,
                                    input logic [DATA_W-1:0] dmax);
        write_limit(REG_POS_MIN, plo);
        write_limit(REG_POS_MAX, phi);
        write_limit(REG_SPD_MIN, slo);
        write_limit(REG_SPD_MAX, shi);
        write_limit(REG_TORQUE_MIN, tlo);
        write_limit(REG_TORQUE_MAX, thi);
        write_limit(REG_STIFF_MAX, kmax);
        write_limit(REG_DAMP_MAX, dmax);
    endtask

    // lower valid and wait until every owed frame has come back
    task automatic settle_frames();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (frames_pending.size() != 0);
    endtask

    // send one command beat; valid stays high afterwards unless the next one idles
    task automatic send_command(input val_t p, input val_t s, input val_t k,
                                input val_t d, input val_t t, input logic hybrid);
        if (idle_send && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.target_pos     <= p;
        cmd_bus.target_spd     <= s;
        cmd_bus.stiff_gain     <= k;
        cmd_bus.damp_gain      <= d;
        cmd_bus.ff_torque      <= t;
        cmd_bus.mode_is_hybrid <= hybrid;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        frames_pending.push_back(pack_frame(p, s, k, d, t, hybrid));
    endtask

    // value aimed at a range: its bounds, just outside, inside, or anywhere at all
    function automatic val_t pick_value(input longint lo, input longint hi);
        longint     v;
        bit [63:0]  rnd;
        rnd = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = lo;
            1:       v = hi;
            2:       v = lo - $urandom_range(1, 1000);
            3:       v = hi + $urandom_range(1, 1000);
            4, 5:    v = $signed($urandom);
            default:
                if (hi > lo)
                    v = lo + longint'(rnd % (hi - lo + 1));
                else
                    v = lo + $signed(32'($urandom_range(0, 2000))) - 1000;
        endcase
        return clip_q(v);
    endfunction

    // random signed range: full width, empty, inverted, narrow, moderate or wide
    task automatic pick_span(output val_t lo, output val_t hi);
        val_t a;
        val_t b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 7))
            0:
            begin
                lo = Q_MIN;
                hi = Q_MAX;
            end
            1:
            begin
                lo = a;
                hi = a;
            end
            2:
            begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            3:
            begin
                lo = a;
                hi = clip_q(longint'(a) + $urandom_range(1, 64));
            end
            4:
            begin
                lo = -$signed(32'($urandom_range(1, 1 << 24)));
                hi = $urandom_range(1, 1 << 24);
            end
            default:
            begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endtask

    // random gain limit; bit 31 of the write is junk that the register drops
    function automatic logic [DATA_W-1:0] pick_gain_limit();
        logic [LIM_W-1:0] g;
        case ($urandom_range(0, 5))
            0:       g = '0;
            1:       g = '1;
            2:       g = $urandom_range(1, 64);
            3:       g = $urandom_range(1, 1 << 26);
            default: g = $urandom;
        endcase
        return {1'($urandom), g};
    endfunction

    task automatic send_random_commands(input int count, input bit allow_idle);
        for (int i = 0; i < count; i++)
        begin
            // change the idling mix every 40 beats so quiet stretches appear too
            if (allow_idle && i % 40 == 0)
            begin
                idle_send = $urandom_range(0, 2) != 0;
                idle_recv = $urandom_range(0, 2) != 0;
            end
            send_command(pick_value(pos_lo, pos_hi), pick_value(spd_lo, spd_hi),
                         pick_value(0, stiff_hi), pick_value(0, damp_hi),
                         pick_value(trq_lo, trq_hi), $urandom_range(0, 7) != 0);
        end
    endtask

    // reset ranges: mode-switch requests, bounds, clamping on both sides
    task automatic test_default_ranges();
        idle_send = 1'b1;
        idle_recv = 1'b1;
        // not in hybrid mode, payload must stay zero whatever the values
        send_command(0, 0, 0, 0, 0, 1'b0);
        send_command(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        send_command(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        // mid range position and speed, gains at their floor
        send_command(0, 0, 0, 0, 0, 1'b1);
        // far below and far above every range; negative gains clamp to zero
        send_command(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
        send_command(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
        // exactly on the bounds
        send_command(pos_lo, spd_lo, 0, 0, trq_lo, 1'b1);
        send_command(pos_hi, spd_hi, stiff_hi, damp_hi, trq_hi, 1'b1);
        // one lsb outside, one lsb inside
        send_command(pos_lo - 1, spd_hi + 1, -1, damp_hi + 1, trq_lo - 1, 1'b1);
        send_command(pos_lo + 1, spd_hi - 1, 1, damp_hi - 1, trq_hi - 1, 1'b1);
        // alternating bit patterns
        send_command(32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555,
                     32'shaaaa_aaaa, 32'sh0000_aaaa, 1'b1);
    endtask

    // widest ranges: 33 bit differences and 48 bit products must not wrap
    task automatic test_full_span();
        settle_frames();
        write_all_limits(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                         32'hffff_ffff, 32'h7fff_ffff);
        send_command(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
        send_command(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
        send_command(0, 0, 0, 0, 0, 1'b1);
        send_command(-1, -1, 1, 32'sh4000_0000, -1, 1'b1);
        send_random_commands(150, 1'b1);
    endtask

    // empty and inverted ranges give code zero whatever the input
    task automatic test_empty_ranges();
        settle_frames();
        write_all_limits(32'sd5, 32'sd5, 32'sd1000, -32'sd1000, Q_MAX, Q_MIN,
                         32'h0000_0000, 32'h8000_0000);
        send_command(32'sd5, 32'sd1000, 0, 0, Q_MAX, 1'b1);
        send_command(Q_MIN, -32'sd1000, Q_MIN, Q_MIN, Q_MIN, 1'b1);
        send_command(Q_MAX, 0, Q_MAX, Q_MAX, 0, 1'b1);
        send_command(32'sd4, 32'sd1001, 1, -1, -1, 1'b1);
        send_random_commands(100, 1'b1);
    endtask

    // fresh random ranges per phase; one phase stops the sender until all frames are back
    task automatic test_random_ranges();
        val_t plo, phi, slo, shi, tlo, thi;
        for (int phase = 0; phase < 6; phase++)
        begin
            settle_frames();
            pick_span(plo, phi);
            pick_span(slo, shi);
            pick_span(tlo, thi);
            write_all_limits(plo, phi, slo, shi, tlo, thi,
                             pick_gain_limit(), pick_gain_limit());
            if (phase == 2)
            begin
                send_random_commands(60, 1'b1);
                settle_frames();
                send_random_commands(60, 1'b1);
            end
            else
            begin
                send_random_commands(120, 1'b1);
            end
        end
    endtask

    // last part: back to default ranges, no gaps on either side
    task automatic test_steady_stream();
        settle_frames();
        write_all_limits(-32'sd819200, 32'sd819200, -32'sd1966080, 32'sd1966080,
                         -32'sd655360, 32'sd655360, 32'd32768000, 32'd327680);
        idle_send = 1'b0;
        idle_recv = 1'b0;
        send_random_commands(160, 1'b0);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.target_pos     = '0;
        cmd_bus.target_spd     = '0;
        cmd_bus.stiff_gain     = '0;
        cmd_bus.damp_gain      = '0;
        cmd_bus.ff_torque      = '0;
        cmd_bus.mode_is_hybrid = 1'b0;
        frame_bus.ready        = 1'b0;
        mismatches             = 0;
        recv_stall_left        = 0;
        idle_send              = 1'b0;
        idle_recv              = 1'b0;
        // register values after reset: +-12.5 position, +-30 speed, +-10 torque,
        // stiffness up to 500, damping up to 5
        pos_lo   = -32'sd819200;
        pos_hi   = 32'sd819200;
        spd_lo   = -32'sd1966080;
        spd_hi   = 32'sd1966080;
        trq_lo   = -32'sd655360;
        trq_hi   = 32'sd655360;
        stiff_hi = 31'd32768000;
        damp_hi  = 31'd327680;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_ranges();
        test_full_span();
        test_empty_ranges();
        test_random_ranges();
        test_steady_stream();

        // drain, then give the pipe time to show any stray beat
        settle_frames();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && frames_pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
